/* src/sobel_edge_point_detector_core_defines.svh */
// ---------------------------------------------------------------------------
// Sobel edge point detector: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_POINT_DETECTOR_CORE_DEFINES_SVH
`define SOBEL_EDGE_POINT_DETECTOR_CORE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define SEPD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SEPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sepd_pkg.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector package
// Sizes, register indexes and the request types shared by the modules.
// ---------------------------------------------------------------------------
package sepd_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;

	localparam int PIXEL_WORD_W = 32;
	localparam int PIX_W        = 8;
	localparam int LINE_W       = 2 * PIX_W;
	localparam int DIM_W        = 12;
	localparam int THR_W        = 11;
	localparam int COORD_W      = 11;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;

	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(2048);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(2048);
	localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(20);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} cfg_reg_t;

	// Window request handed from the line store stage to the gradient pipe.
	typedef struct packed {
		logic                        valid;
		logic                        check;
		logic [8:0][PIX_W-1:0]       win;
		logic [COORD_W-1:0]          x;
		logic [COORD_W-1:0]          y;
	} win_req_t;

	// Final decision for one item.
	typedef struct packed {
		logic               done;
		logic               hit;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} verdict_t;

	// Clamp a frame dimension to 1..hi.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		logic [DIM_W-1:0] res;
		res = v;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > hi) begin
			res = DIM_W'(hi);
		end
		return res;
	endfunction

endpackage

/* src/sepd_ifs.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector interfaces
// Pixel request channel, edge point channel and configuration write channel.
// ---------------------------------------------------------------------------
interface sepd_pix_if import sepd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic [PIXEL_WORD_W-1:0] pixel_word;

	modport source (output valid, output mode, output pixel_word, input ready);
	modport sink (input valid, input mode, input pixel_word, output ready);
endinterface

interface sepd_edge_if import sepd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] edge_x;
	logic [COORD_W-1:0] edge_y;

	modport source (output valid, output edge_x, output edge_y, input ready);
	modport sink (input valid, input edge_x, input edge_y, output ready);
endinterface

interface sepd_cfg_if import sepd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/sobel_edge_point_detector_core.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector core
// Streams raster pixels through a 3x3 Sobel window and reports edge points.
// ---------------------------------------------------------------------------
// Send the pixels of a frame in raster order, then image_width+1 flush
// requests (mode 1) to drain the last row. The core takes one request per
// clock while ready is high: the line store is one dual-port RAM that is
// read for a column in the accept cycle and written back in the next, with
// the last write forwarded when it hits the same column. A reported point
// (edge_x, edge_y) comes out for the request image_width+1 positions later
// and passes s1 and s2 of the line stage and s3 and s4 of the gradient pipe
// before it is queued; an eight-entry result queue lets the input keep
// flowing while the output side stalls, and the input drops ready once eight
// requests are pending. After reset the core zeroes all 2048 line store
// entries and takes no pixel request in that time; configuration writes are
// taken at any time but must only be made while no request is in flight.
// ---------------------------------------------------------------------------
module sobel_edge_point_detector_core import sepd_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	sepd_pix_if.sink     pixels,
	sepd_edge_if.source  points,
	sepd_cfg_if.sink     cfg
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [THR_W-1:0] thresh_q;
	logic [DIM_W-1:0] w_dim;
	logic [DIM_W-1:0] h_dim;

	logic             busy;
	logic             acc;
	logic             pop;
	logic             drop;
	logic [CNT_W-1:0] pending_q;
	win_req_t         win_req;
	verdict_t         verdict;

	// Configuration writes: always ready, unknown indexes are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg.data;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg.data;
				end
				REG_EDGE_THRESHOLD: begin
					thresh_q <= cfg.data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign w_dim = clamp_dim(width_q, MAX_WIDTH);
	assign h_dim = clamp_dim(height_q, MAX_HEIGHT);

	// Credit: every accepted request either drops out of the gradient pipe
	// without a point or holds a queue slot until the point is taken.
	assign pixels.ready = !busy && (pending_q < CNT_W'(FIFO_DEPTH));
	assign acc          = pixels.valid && pixels.ready;
	assign drop         = verdict.done && !verdict.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(acc) - CNT_W'(pop) - CNT_W'(drop);
		end
	end

	sepd_line_window u_line_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.mode       (pixels.mode),
		.pixel_word (pixels.pixel_word),
		.w_dim      (w_dim),
		.h_dim      (h_dim),
		.busy       (busy),
		.win_req    (win_req)
	);

	sepd_gradient u_gradient (
		.clk     (clk),
		.arst_n  (arst_n),
		.win_req (win_req),
		.thresh  (thresh_q),
		.verdict (verdict)
	);

	sepd_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.verdict (verdict),
		.ready   (points.ready),
		.valid   (points.valid),
		.edge_x  (points.edge_x),
		.edge_y  (points.edge_y),
		.pop     (pop)
	);

endmodule

/* src/sepd_ram.sv */
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sepd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/sepd_line_window.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector line stage
// Scan position, line store read-modify-write and the 3x3 window.
// ---------------------------------------------------------------------------
module sepd_line_window import sepd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc,
	input  logic                    mode,
	input  logic [PIXEL_WORD_W-1:0] pixel_word,
	input  logic [DIM_W-1:0]        w_dim,
	input  logic [DIM_W-1:0]        h_dim,
	output logic                    busy,
	output win_req_t                win_req
);

	// Integer mean of three bytes: multiply by 683/2048, exact up to 765.
	function automatic logic [PIX_W-1:0] to_gray(input logic [23:0] rgb);
		logic [PIX_W+1:0] sum;
		logic [20:0]      prod;
		sum  = (PIX_W+2)'(rgb[23:16]) + (PIX_W+2)'(rgb[15:8]) + (PIX_W+2)'(rgb[7:0]);
		prod = 21'(sum) * 21'(683);
		return prod[18:11];
	endfunction

	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [DIM_W:0]        col_inc;
	logic                  col_wrap;
	logic                  frame_end;

	logic                  busy_q;
	logic [COL_W-1:0]      clr_addr_q;

	logic                  v_s1;
	logic [COL_W-1:0]      col_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [PIX_W-1:0]      gray_s1;

	logic                  ram_we;
	logic [COL_W-1:0]      ram_waddr;
	logic [LINE_W-1:0]     ram_wdata;
	logic [LINE_W-1:0]     ram_rdata;

	logic                  fwd_v_q;
	logic [COL_W-1:0]      fwd_col_q;
	logic [LINE_W-1:0]     fwd_data_q;

	logic [LINE_W-1:0]     line_rd;
	logic [ROW_W:0]        row_x;
	logic [ROW_W:0]        h_x;
	logic [PIX_W-1:0]      top;
	logic [PIX_W-1:0]      mid;
	logic [PIX_W-1:0]      bot;
	logic [2:0][PIX_W-1:0] newcol;
	logic                  col0;
	logic [8:0][PIX_W-1:0] win_q;
	logic [8:0][PIX_W-1:0] win_eval;
	logic [8:0][PIX_W-1:0] win_nx;
	logic                  check;
	logic [COORD_W-1:0]    ex;
	logic [COORD_W-1:0]    ey;

	logic                  v_s2;
	logic                  check_s2;
	logic [8:0][PIX_W-1:0] win_s2;
	logic [COORD_W-1:0]    x_s2;
	logic [COORD_W-1:0]    y_s2;

	// Scan position of the next request.
	always_comb begin
		col_inc   = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);
		col_wrap  = col_inc >= (DIM_W+1)'(w_dim);
		frame_end = (col_q == '0) &&
			((ROW_W+1)'(row_q) >= (ROW_W+1)'(h_dim) + (ROW_W+1)'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Zero the line store once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			gray_s1 <= mode ? '0 : to_gray(pixel_word[23:0]);
		end
	end

	// Entry layout: upper line byte over middle line byte.
	sepd_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		// Forward the previous write when it hit the entry read in the same edge.
		line_rd = (fwd_v_q && (fwd_col_q == col_s1)) ? fwd_data_q : ram_rdata;
		row_x   = (ROW_W+1)'(row_s1);
		h_x     = (ROW_W+1)'(h_dim);

		top = ((row_x >= (ROW_W+1)'(2)) && (row_x <= h_x + (ROW_W+1)'(1))) ?
			line_rd[LINE_W-1:PIX_W] : '0;
		mid = ((row_x >= (ROW_W+1)'(1)) && (row_x <= h_x)) ? line_rd[PIX_W-1:0] : '0;
		bot = (row_x < h_x) ? gray_s1 : '0;

		newcol[0] = top;
		newcol[1] = mid;
		newcol[2] = bot;
		col0      = (col_s1 == '0);

		for (int k = 0; k < 3; k++) begin
			win_eval[k*3]     = win_q[k*3+1];
			win_eval[k*3+1]   = win_q[k*3+2];
			win_eval[k*3+2]   = col0 ? '0 : newcol[k];
			win_nx[k*3]       = col0 ? '0 : win_eval[k*3];
			win_nx[k*3+1]     = col0 ? '0 : win_eval[k*3+1];
			win_nx[k*3+2]     = newcol[k];
		end

		if (col0) begin
			// Close the last column of the row before: right neighbor is outside.
			check = (row_x >= (ROW_W+1)'(2)) && (row_x < h_x + (ROW_W+1)'(2));
			ex    = COORD_W'(w_dim - DIM_W'(1));
			ey    = COORD_W'(row_s1 - ROW_W'(2));
		end else begin
			check = (row_x >= (ROW_W+1)'(1)) && (row_x < h_x + (ROW_W+1)'(1)) &&
				((DIM_W+1)'(col_s1 - COL_W'(1)) < (DIM_W+1)'(w_dim));
			ex    = COORD_W'(col_s1 - COL_W'(1));
			ey    = COORD_W'(row_s1 - ROW_W'(1));
		end

		ram_we    = busy_q || v_s1;
		ram_waddr = busy_q ? clr_addr_q : col_s1;
		ram_wdata = busy_q ? '0 : {mid, bot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
			win_q   <= '0;
			v_s2    <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
			v_s2    <= v_s1;
			if (v_s1) begin
				win_q <= win_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_col_q  <= col_s1;
		fwd_data_q <= {mid, bot};
		check_s2   <= check;
		win_s2     <= win_eval;
		x_s2       <= ex;
		y_s2       <= ey;
	end

	assign win_req = '{valid: v_s2, check: check_s2, win: win_s2, x: x_s2, y: y_s2};

endmodule

/* src/sepd_gradient.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector gradient pipe
// Kernel sums, squares and the threshold compare over three stages.
// ---------------------------------------------------------------------------
module sepd_gradient import sepd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  win_req_t         win_req,
	input  logic [THR_W-1:0] thresh,
	output verdict_t         verdict
);

	localparam int SUM_W = PIX_W + 2;
	localparam int SQ_W  = 2 * SUM_W;
	localparam int T_W   = THR_W + 1;
	localparam int TSQ_W = 2 * T_W;

	logic [SUM_W-1:0]   px;
	logic [SUM_W-1:0]   nx;
	logic [SUM_W-1:0]   py;
	logic [SUM_W-1:0]   ny;
	logic [SUM_W:0]     gx;
	logic [SUM_W:0]     gy;
	logic [SUM_W:0]     ax;
	logic [SUM_W:0]     ay;

	logic               v_s3;
	logic               check_s3;
	logic [SUM_W-1:0]   ax_s3;
	logic [SUM_W-1:0]   ay_s3;
	logic [COORD_W-1:0] x_s3;
	logic [COORD_W-1:0] y_s3;

	logic               v_s4;
	logic               check_s4;
	logic [SQ_W-1:0]    sqx_s4;
	logic [SQ_W-1:0]    sqy_s4;
	logic [COORD_W-1:0] x_s4;
	logic [COORD_W-1:0] y_s4;

	logic [T_W-1:0]     t;
	logic [TSQ_W-1:0]   tsq_q;
	logic [SQ_W:0]      mag;

	always_comb begin
		px = SUM_W'(win_req.win[2]) + {win_req.win[5], 1'b0} + SUM_W'(win_req.win[8]);
		nx = SUM_W'(win_req.win[0]) + {win_req.win[3], 1'b0} + SUM_W'(win_req.win[6]);
		py = SUM_W'(win_req.win[6]) + {win_req.win[7], 1'b0} + SUM_W'(win_req.win[8]);
		ny = SUM_W'(win_req.win[0]) + {win_req.win[1], 1'b0} + SUM_W'(win_req.win[2]);
		gx = {1'b0, px} - {1'b0, nx};
		gy = {1'b0, py} - {1'b0, ny};
		ax = gx[SUM_W] ? (~gx + (SUM_W+1)'(1)) : gx;
		ay = gy[SUM_W] ? (~gy + (SUM_W+1)'(1)) : gy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= win_req.valid;
			v_s4 <= v_s3;
		end
	end

	// Threshold square follows the register; it settles well before any request.
	assign t = T_W'(thresh) + T_W'(1);

	always_ff @(posedge clk) begin
		tsq_q    <= TSQ_W'(t) * TSQ_W'(t);
		check_s3 <= win_req.check;
		ax_s3    <= ax[SUM_W-1:0];
		ay_s3    <= ay[SUM_W-1:0];
		x_s3     <= win_req.x;
		y_s3     <= win_req.y;
		check_s4 <= check_s3;
		sqx_s4   <= SQ_W'(ax_s3) * SQ_W'(ax_s3);
		sqy_s4   <= SQ_W'(ay_s3) * SQ_W'(ay_s3);
		x_s4     <= x_s3;
		y_s4     <= y_s3;
	end

	always_comb begin
		mag             = (SQ_W+1)'(sqx_s4) + (SQ_W+1)'(sqy_s4);
		verdict.done    = v_s4;
		verdict.hit     = v_s4 && check_s4 && (TSQ_W'(mag) >= tsq_q);
		verdict.x       = x_s4;
		verdict.y       = y_s4;
	end

endmodule

/* src/sepd_out_fifo.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector result queue
// Small queue of edge points in front of the output channel.
// ---------------------------------------------------------------------------
module sepd_out_fifo import sepd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  verdict_t           verdict,
	input  logic               ready,
	output logic               valid,
	output logic [COORD_W-1:0] edge_x,
	output logic [COORD_W-1:0] edge_y,
	output logic               pop
);

	logic [2*COORD_W-1:0] slots [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 push;

	assign push  = verdict.hit;
	assign valid = (count_q != '0);
	assign pop   = valid && ready;
	assign edge_x = slots[rd_ptr_q][2*COORD_W-1:COORD_W];
	assign edge_y = slots[rd_ptr_q][COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= {verdict.x, verdict.y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

/* src/sepd_checker.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector port checker
// Watches the core's ports: output hold rules and point coordinates in frame.
// ---------------------------------------------------------------------------
`include "sobel_edge_point_detector_core_defines.svh"

module sepd_checker import sepd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_W-1:0]    edge_x,
	input logic [COORD_W-1:0]    edge_y
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] w_chk;
	logic [DIM_W-1:0] h_chk;

	// Track the frame size as written on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign w_chk = clamp_dim(width_q, MAX_WIDTH);
	assign h_chk = clamp_dim(height_q, MAX_HEIGHT);

	`SEPD_ASSERT_NEXT(a_point_held, out_valid && !out_ready, out_valid, "point dropped while stalled")
	`SEPD_ASSERT_NEXT(a_point_stable, out_valid && !out_ready, $stable(edge_x) && $stable(edge_y), "point changed while stalled")
	`SEPD_ASSERT_SAME(a_x_in_row, out_valid, DIM_W'(edge_x) < w_chk, "edge_x beyond image width")
	`SEPD_ASSERT_SAME(a_y_in_frame, out_valid, DIM_W'(edge_y) < h_chk, "edge_y beyond image height")

endmodule

bind sobel_edge_point_detector_core sepd_checker u_sepd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_index (cfg.index),
	.cfg_data  (cfg.data),
	.out_valid (points.valid),
	.out_ready (points.ready),
	.edge_x    (points.edge_x),
	.edge_y    (points.edge_y)
);

/* bench/tb_sobel_edge_point_detector_core.sv */
// ---------------------------------------------------------------------------
// Sobel edge point detector core testbench
// Streams pixel frames through the core and checks each reported edge point
// against a cycle-free model of the 3x3 window, line stores and threshold.
// ---------------------------------------------------------------------------
module tb_sobel_edge_point_detector_core import sepd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int IDLE_PERCENT  = 23;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int STEADY_ITEMS  = 300;
	localparam int PARTIAL_ITEMS = 30;
	localparam int REPORT_LIMIT  = 10;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} edge_point_t;

	// Picture content used for whole frames.
	typedef enum int {
		SCENE_NOISE,
		SCENE_FLAT,
		SCENE_VERTICAL,
		SCENE_HORIZONTAL,
		SCENE_GRAIN
	} scene_t;

	logic clk = 1'b0;
	logic arst_n;

	sepd_pix_if  pix_ch ();
	sepd_edge_if pt_ch ();
	sepd_cfg_if  cfg_ch ();

	sobel_edge_point_detector_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch),
		.points (pt_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the core: line stores, window, raster position, registers.
	logic [PIX_W-1:0] upper_row_model [MAX_WIDTH];
	logic [PIX_W-1:0] middle_row_model [MAX_WIDTH];
	logic [PIX_W-1:0] window_model [9];
	int unsigned      model_col;
	int unsigned      model_row;
	logic [DIM_W-1:0] width_setting;
	logic [DIM_W-1:0] height_setting;
	logic [THR_W-1:0] threshold_setting;

	edge_point_t expected_points [$];
	edge_point_t oldest_point;
	int unsigned mismatches   = 0;
	int unsigned stall_cycles = 0;
	int unsigned random_items = 0;
	bit          count_random = 1'b0;
	// High during the stretch in which neither side idles.
	bit          steady_flow  = 1'b0;

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// Clamp a dimension register to the range the core works with.
	function automatic int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned hi);
		if (v == '0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Gray level: truncated mean of red, green and blue.
	function automatic logic [PIX_W-1:0] luma_of(logic [PIXEL_WORD_W-1:0] w);
		int unsigned sum;
		sum = w[23:16] + w[15:8] + w[7:0];
		return PIX_W'(sum / 3);
	endfunction

	// Compare the squared gradient against the square of (threshold plus one),
	// which avoids a square root.
	function automatic bit window_over_threshold();
		int          gx;
		int          gy;
		int unsigned limit;
		gx = (int'(window_model[2]) + 2 * int'(window_model[5]) + int'(window_model[8]))
		   - (int'(window_model[0]) + 2 * int'(window_model[3]) + int'(window_model[6]));
		gy = (int'(window_model[6]) + 2 * int'(window_model[7]) + int'(window_model[8]))
		   - (int'(window_model[0]) + 2 * int'(window_model[1]) + int'(window_model[2]));
		limit = threshold_setting + 1;
		return gx * gx + gy * gy >= limit * limit;
	endfunction

	// Shift the window one column left and load the new right column.
	function automatic void slide_window(logic [PIX_W-1:0] top, mid, bot);
		for (int r = 0; r < 3; r++) begin
			window_model[r * 3]     = window_model[r * 3 + 1];
			window_model[r * 3 + 1] = window_model[r * 3 + 2];
		end
		window_model[2] = top;
		window_model[5] = mid;
		window_model[8] = bot;
	endfunction

	// Advance the model by one accepted request and queue the edge point,
	// if any, that the request completes.
	function automatic void predict_edge_point(logic md, logic [PIXEL_WORD_W-1:0] word);
		int unsigned      w;
		int unsigned      h;
		int unsigned      c;
		int unsigned      r;
		int unsigned      ci;
		int unsigned      ex;
		int unsigned      ey;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		bit               hit;
		w   = usable_dim(width_setting, MAX_WIDTH);
		h   = usable_dim(height_setting, MAX_HEIGHT);
		c   = model_col;
		r   = model_row;
		ci  = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
		hit = 1'b0;
		ex  = 0;
		ey  = 0;
		// Mask out rows above the frame and stale line store contents.
		top = (r >= 2 && r <= h + 1) ? upper_row_model[ci] : '0;
		mid = (r >= 1 && r <= h) ? middle_row_model[ci] : '0;
		bot = (r < h && md == MODE_PIXEL) ? luma_of(word) : '0;
		if (c == 0) begin
			// Close the last column of the row before last: right side is outside.
			slide_window('0, '0, '0);
			if (r >= 2 && r - 2 < h) begin
				hit = window_over_threshold();
				ex  = w - 1;
				ey  = r - 2;
			end
			foreach (window_model[i]) window_model[i] = '0;
			window_model[2] = top;
			window_model[5] = mid;
			window_model[8] = bot;
		end else begin
			slide_window(top, mid, bot);
			if (r >= 1 && r - 1 < h && c - 1 < w) begin
				hit = window_over_threshold();
				ex  = c - 1;
				ey  = r - 1;
			end
		end
		upper_row_model[ci]  = mid;
		middle_row_model[ci] = bot;
		if (c == 0 && r >= h + 1) begin
			model_col = 0;
			model_row = 0;
		end else if (c + 1 >= w) begin
			model_col = 0;
			model_row = r + 1;
		end else begin
			model_col = c + 1;
		end
		if (hit) expected_points.push_back(edge_point_t'{x: COORD_W'(ex), y: COORD_W'(ey)});
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [PIX_W-1:0] shade(int unsigned lvl, int unsigned spread);
		int v;
		v = int'(lvl) + int'($urandom_range(2 * spread)) - int'(spread);
		if (v < 0) v = 0;
		else if (v > 255) v = 255;
		return PIX_W'(v);
	endfunction

	// Build one packed pixel; the unused top byte is always random.
	function automatic logic [PIXEL_WORD_W-1:0] scene_pixel(scene_t scene,
			int unsigned x, y, lo, hi, split_x, split_y);
		int unsigned lvl;
		int unsigned spread;
		if (scene == SCENE_NOISE) return $urandom();
		lvl    = lo;
		spread = 0;
		case (scene)
			SCENE_VERTICAL: begin
				lvl = (x < split_x) ? lo : hi;
			end
			SCENE_HORIZONTAL: begin
				lvl = (y < split_y) ? lo : hi;
			end
			SCENE_GRAIN: begin
				spread = 6;
			end
			default: begin
			end
		endcase
		return {8'($urandom()), shade(lvl, spread), shade(lvl, spread), shade(lvl, spread)};
	endfunction

	// Send one request: idle first at random, then hold it until taken.
	// Valid is lowered only for the random idles, so requests sent without an idle keep it high.
	task automatic send_request(input logic md, input logic [PIXEL_WORD_W-1:0] word);
		while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.mode       <= md;
		pix_ch.pixel_word <= word;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		predict_edge_point(md, word);
		if (count_random) random_items++;
	endtask

	// Drop valid, let every expected point arrive, then give requests that
	// report nothing time to leave the pipe.
	task automatic wait_for_drain();
		pix_ch.valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH: begin
				width_setting = value;
			end
			REG_IMAGE_HEIGHT: begin
				height_setting = value;
			end
			REG_EDGE_THRESHOLD: begin
				threshold_setting = value[THR_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, h, thr);
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(REG_EDGE_THRESHOLD, thr);
	endtask

	// Flush until the raster position returns to the frame origin.
	task automatic flush_to_origin();
		while (model_col != 0 || model_row != 0) send_request(MODE_FLUSH, $urandom());
	endtask

	// One well-formed frame: all pixels in raster order, then the drain.
	task automatic stream_frame(input scene_t scene);
		int unsigned w;
		int unsigned h;
		int unsigned lo;
		int unsigned hi;
		int unsigned split_x;
		int unsigned split_y;
		w       = usable_dim(width_setting, MAX_WIDTH);
		h       = usable_dim(height_setting, MAX_HEIGHT);
		lo      = $urandom_range(255);
		hi      = $urandom_range(255);
		split_x = $urandom_range(w);
		split_y = $urandom_range(h);
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				send_request(MODE_PIXEL, scene_pixel(scene, x, y, lo, hi, split_x, split_y));
			end
		end
		flush_to_origin();
	endtask

	// A frame with flushes mixed into the pixels and pixels in the drain rows.
	task automatic stream_broken();
		repeat ($urandom_range(1, 40)) begin
			send_request(($urandom_range(99) < 30) ? MODE_FLUSH : MODE_PIXEL, $urandom());
		end
		while (model_col != 0 || model_row != 0) begin
			send_request(($urandom_range(99) < 50) ? MODE_FLUSH : MODE_PIXEL, $urandom());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme pixel words on a small frame at the reset threshold.
	task automatic test_field_extremes();
		logic [PIXEL_WORD_W-1:0] corner_words [12] = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
			32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FFFF, 32'h0001_0101,
			32'h00FE_FEFE, 32'h8080_8080, 32'h7F7F_7F7F, 32'h0000_0000
		};
		wait_for_drain();
		write_register(REG_IMAGE_WIDTH, 12'd4);
		write_register(REG_IMAGE_HEIGHT, 12'd3);
		foreach (corner_words[i]) send_request(MODE_PIXEL, corner_words[i]);
		flush_to_origin();
	endtask

	// Flush inside the image and pixel requests in the drain rows.
	task automatic test_special_cases();
		wait_for_drain();
		configure(12'd3, 12'd2, 12'd0);
		send_request(MODE_PIXEL, 32'h00FF_FFFF);
		// Flush inside the frame reads as a black pixel.
		send_request(MODE_FLUSH, 32'hFFFF_FFFF);
		send_request(MODE_PIXEL, 32'h0040_8020);
		send_request(MODE_PIXEL, 32'h00FF_FFFF);
		send_request(MODE_PIXEL, 32'h0000_0000);
		send_request(MODE_PIXEL, 32'h00C0_C0C0);
		// Drain with bright pixels: their values must be dropped.
		while (model_col != 0 || model_row != 0) send_request(MODE_PIXEL, 32'h00FF_FFFF);
	endtask

	// Clamped and full-size dimensions, threshold zero and out of reach.
	// Full-size frames are cut short and closed by shrinking the frame.
	task automatic test_register_extremes();
		wait_for_drain();
		configure(12'd0, 12'd0, 12'd5);
		stream_frame(SCENE_NOISE);
		wait_for_drain();
		configure(12'hFFF, 12'd1, 12'd0);
		repeat (PARTIAL_ITEMS) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		write_register(REG_IMAGE_WIDTH, 12'd4);
		flush_to_origin();
		wait_for_drain();
		configure(12'd2048, 12'd2, 12'd100);
		repeat (PARTIAL_ITEMS) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		write_register(REG_IMAGE_WIDTH, 12'd5);
		flush_to_origin();
		wait_for_drain();
		configure(12'd1, 12'hFFF, 12'd40);
		repeat (PARTIAL_ITEMS) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		write_register(REG_IMAGE_HEIGHT, 12'd3);
		flush_to_origin();
		wait_for_drain();
		// Bit 11 of the data is outside the threshold register.
		configure(12'd5, 12'd4, 12'hFFF);
		stream_frame(SCENE_NOISE);
		wait_for_drain();
		configure(12'd6, 12'd5, 12'd1443);
		stream_frame(SCENE_VERTICAL);
		wait_for_drain();
		configure(12'd7, 12'd4, 12'd10);
		stream_frame(SCENE_HORIZONTAL);
	endtask

	// Change width and height while a frame is half done.
	task automatic test_midframe_settings();
		wait_for_drain();
		configure(12'd8, 12'd6, 12'd30);
		repeat (21) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		// Column is past the new last column: it must wrap on the next request.
		write_register(REG_IMAGE_WIDTH, 12'd3);
		repeat (7) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		// Row is past the new frame end: the frame restarts at column zero.
		write_register(REG_IMAGE_HEIGHT, 12'd2);
		repeat (5) send_request(MODE_PIXEL, $urandom());
		wait_for_drain();
		write_register(REG_IMAGE_WIDTH, 12'd12);
		flush_to_origin();
	endtask

	// Mostly whole frames with random content and settings, some broken ones.
	task automatic test_random_streams();
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		logic [CFG_DATA_W-1:0] thr;
		int unsigned           pick;
		wait_for_drain();
		count_random = 1'b1;
		steady_flow  = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= STEADY_ITEMS) steady_flow = 1'b0;
			if ($urandom_range(2) == 0) begin
				w    = ($urandom_range(99) < 5) ? '0 : CFG_DATA_W'($urandom_range(1, 24));
				h    = ($urandom_range(99) < 5) ? '0 : CFG_DATA_W'($urandom_range(1, 10));
				pick = $urandom_range(99);
				if (pick < 10) thr = '0;
				else if (pick < 15) thr = CFG_DATA_W'($urandom_range(1443, 2047));
				else thr = CFG_DATA_W'($urandom_range(1, 300));
				// Settings change only with nothing in flight.
				wait_for_drain();
				configure(w, h, thr);
			end
			if ($urandom_range(99) < 85) stream_frame(scene_t'($urandom_range(SCENE_GRAIN)));
			else stream_broken();
		end
		count_random = 1'b0;
		steady_flow  = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, in-order compare, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		pt_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Compare each accepted point with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: unexpected edge point x=%0d y=%0d", $realtime,
						pt_ch.edge_x, pt_ch.edge_y);
				end
			end else begin
				oldest_point = expected_points.pop_front();
				if (pt_ch.edge_x !== oldest_point.x || pt_ch.edge_y !== oldest_point.y) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: edge point expected x=%0d y=%0d, got x=%0d y=%0d",
							$realtime, oldest_point.x, oldest_point.y,
							pt_ch.edge_x, pt_ch.edge_y);
					end
				end
			end
		end
	end

	// Count cycles in which no channel moves anything; give up at the limit.
	// The limit covers the line store clearing pass after reset.
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (pt_ch.valid && pt_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// Model starts from the reset state of the core.
		foreach (upper_row_model[i]) upper_row_model[i] = '0;
		foreach (middle_row_model[i]) middle_row_model[i] = '0;
		foreach (window_model[i]) window_model[i] = '0;
		model_col         = 0;
		model_row         = 0;
		width_setting     = WIDTH_RESET;
		height_setting    = HEIGHT_RESET;
		threshold_setting = THRESH_RESET;

		arst_n            <= 1'b0;
		pix_ch.valid      <= 1'b0;
		pix_ch.mode       <= MODE_PIXEL;
		pix_ch.pixel_word <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_IMAGE_WIDTH;
		cfg_ch.data       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_special_cases();
		test_register_extremes();
		test_midframe_settings();
		test_random_streams();

		// Hold off until every point is in and stray output would have shown.
		wait_for_drain();
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/sepd_pkg.sv
src/sepd_ifs.sv
src/sepd_ram.sv
src/sepd_line_window.sv
src/sepd_gradient.sv
src/sepd_out_fifo.sv
src/sobel_edge_point_detector_core.sv
src/sepd_checker.sv
bench/tb_sobel_edge_point_detector_core.sv
